>>> hw/rtl/ncsi_cbs_pkg.sv
// shared types, command codes and status codes of the nc-si bring-up sequencer
package ncsi_cbs_pkg;

  localparam int unsigned HeaderBytes = 16;

  localparam int unsigned MacW    = 48;
  localparam int unsigned RetryW  = 8;
  localparam int unsigned ChanW   = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 48;

  localparam logic [7:0] CmdCis  = 8'h00;
  localparam logic [7:0] CmdSp   = 8'h01;
  localparam logic [7:0] CmdDp   = 8'h02;
  localparam logic [7:0] CmdEc   = 8'h03;
  localparam logic [7:0] CmdEcnt = 8'h06;
  localparam logic [7:0] CmdGls  = 8'h0A;
  localparam logic [7:0] CmdSma  = 8'h0E;
  localparam logic [7:0] CmdEbf  = 8'h10;
  localparam logic [7:0] RspFlag = 8'h80;

  localparam logic [4:0]  ChanLowBits  = 5'h1f;
  localparam logic [63:0] FilterWord   = 64'h0000_000F_0000_0000;
  localparam logic [15:0] SmaTailBytes = 16'h0101;
  localparam logic [3:0]  PlenNone     = 4'd0;
  localparam logic [3:0]  PlenWord     = 4'd4;
  localparam logic [3:0]  PlenDouble   = 4'd8;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_RSP     = 2'd1,
    OP_TIMEOUT = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_UNEXP     = 3'd2,
    ST_FAILED    = 3'd3,
    ST_UNKNOWN   = 3'd4,
    ST_TIMEOUT   = 3'd5,
    ST_LINK_DOWN = 3'd6
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAC   = 2'd0,
    CFG_RETRY = 2'd1,
    CFG_CHAN  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [MacW-1:0]   mac_address;
    logic [RetryW-1:0] retry_limit;
    logic [ChanW-1:0]  channel_index;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [10:0] rsp_length;
    logic [7:0]  rsp_type;
    logic [7:0]  rsp_id;
    logic [15:0] rsp_code;
    logic [7:0]  rsp_channel;
    logic [31:0] link_status;
  } req_t;

  typedef struct packed {
    logic        send;
    logic [7:0]  cmd_type;
    logic [7:0]  req_id;
    logic [7:0]  channel_byte;
    logic [3:0]  payload_len;
    logic [63:0] payload_word;
    logic [2:0]  status;
    logic        fail;
  } res_t;

endpackage

>>> hw/rtl/ncsi_cbs_cfg_regs.sv
// configuration registers: mac address, retry limit and channel index
module ncsi_cbs_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ncsi_cbs_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [ncsi_cbs_pkg::CfgDatW-1:0]    cfg_data_i,
  output ncsi_cbs_pkg::cfg_t                  cfg_o
);
  import ncsi_cbs_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MAC:   cfg_d.mac_address   = cfg_data_i[MacW-1:0];
        CFG_RETRY: cfg_d.retry_limit   = cfg_data_i[RetryW-1:0];
        CFG_CHAN:  cfg_d.channel_index = cfg_data_i[ChanW-1:0];
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mac_address   <= '0;
      cfg_q.retry_limit   <= RetryW'(10);
      cfg_q.channel_index <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hw/rtl/ncsi_cbs_core.sv
// response check, next command choice and sequence state registers
module ncsi_cbs_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  ncsi_cbs_pkg::req_t  req_i,
  input  ncsi_cbs_pkg::cfg_t  cfg_i,
  output ncsi_cbs_pkg::res_t  res_o
);
  import ncsi_cbs_pkg::*;

  logic [7:0]        last_cmd_q, last_cmd_d;
  logic [7:0]        last_id_q, last_id_d;
  logic [RetryW-1:0] retries_q, retries_d;

  logic        do_issue;
  logic [7:0]  nxt_cmd;
  logic [2:0]  chan_sel;
  logic [3:0]  plen;
  logic [63:0] pword;
  logic [7:0]  nxt_id;
  res_t        res;

  assign nxt_id = last_id_q + 8'd1;

  always_comb begin
    res       = '0;
    do_issue  = 1'b0;
    nxt_cmd   = CmdDp;
    chan_sel  = cfg_i.channel_index;
    plen      = PlenNone;
    pword     = '0;
    retries_d = retries_q;
    unique case (req_i.op)
      OP_START: begin
        retries_d = cfg_i.retry_limit;
        do_issue  = 1'b1;
        nxt_cmd   = CmdDp;
      end
      OP_TIMEOUT: begin
        res.status = ST_TIMEOUT;
        res.fail   = 1'b1;
      end
      OP_RSP: begin
        priority if (req_i.rsp_length < 11'(HeaderBytes)) begin
          res.status = ST_SHORT;
        end else if (req_i.rsp_type != (last_cmd_q | RspFlag)
                     || req_i.rsp_id != last_id_q) begin
          res.status = ST_UNEXP;
        end else if (req_i.rsp_code != '0) begin
          res.status = ST_FAILED;
        end else begin
          unique case (req_i.rsp_type)
            CmdDp | RspFlag: begin
              do_issue = 1'b1;
              nxt_cmd  = CmdSp;
              plen     = PlenWord;
              pword    = FilterWord;
            end
            CmdSp | RspFlag: begin
              do_issue = 1'b1;
              nxt_cmd  = CmdCis;
            end
            CmdCis | RspFlag: begin
              do_issue = 1'b1;
              nxt_cmd  = CmdSma;
              plen     = PlenDouble;
              pword    = {cfg_i.mac_address, SmaTailBytes};
            end
            CmdSma | RspFlag: begin
              do_issue = 1'b1;
              nxt_cmd  = CmdEbf;
              plen     = PlenWord;
              pword    = FilterWord;
            end
            CmdEbf | RspFlag: begin
              do_issue = 1'b1;
              nxt_cmd  = CmdEcnt;
            end
            CmdEcnt | RspFlag: begin
              do_issue = 1'b1;
              nxt_cmd  = CmdEc;
            end
            CmdEc | RspFlag: begin
              do_issue = 1'b1;
              nxt_cmd  = CmdGls;
            end
            CmdGls | RspFlag: begin
              if (req_i.link_status == '0) begin
                if (retries_q != '0) begin
                  retries_d = retries_q - RetryW'(1);
                  do_issue  = 1'b1;
                  nxt_cmd   = CmdGls;
                  chan_sel  = req_i.rsp_channel[2:0];
                end else begin
                  res.status = ST_LINK_DOWN;
                end
              end
            end
            default: res.status = ST_UNKNOWN;
          endcase
        end
      end
      default: res = '0;
    endcase

    if (do_issue) begin
      res.send         = 1'b1;
      res.cmd_type     = nxt_cmd;
      res.req_id       = nxt_id;
      res.channel_byte = {chan_sel, ChanLowBits};
      res.payload_len  = plen;
      res.payload_word = pword;
    end

    last_id_d  = do_issue ? nxt_id : last_id_q;
    last_cmd_d = do_issue ? nxt_cmd : last_cmd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_cmd_q <= '0;
      last_id_q  <= '0;
      retries_q  <= RetryW'(10);
    end else if (fire_i) begin
      last_cmd_q <= last_cmd_d;
      last_id_q  <= last_id_d;
      retries_q  <= retries_d;
    end
  end

  assign res_o = res;

endmodule

>>> hw/rtl/ncsi_channel_bringup_sequencer_unit.sv
// top level of the nc-si channel bring-up sequencer
//
//   channel  direction  handshake                  payload
//   in       sink       in_valid_i / in_ready_o    op_i, rsp_*_i, link_status_i
//   out      source     out_valid_o / out_ready_i  send_o .. fail_o
//   cfg      sink       cfg_we_i (no wait)         cfg_index_i, cfg_data_i
//
// one request per cycle sustained while out_ready_i is high; a request passes
// through the input register, then decode and the result register
// the sequence state updates in the same cycle the result register loads
// reset clears valids, configuration and sequence state; retry limit is 10
// a stalled result holds the input register, which then holds in_ready_o low
module ncsi_channel_bringup_sequencer_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ncsi_cbs_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [ncsi_cbs_pkg::CfgDatW-1:0] cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [1:0]                       op_i,
  input  logic [10:0]                      rsp_length_i,
  input  logic [7:0]                       rsp_type_i,
  input  logic [7:0]                       rsp_id_i,
  input  logic [15:0]                      rsp_code_i,
  input  logic [7:0]                       rsp_channel_i,
  input  logic [31:0]                      link_status_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             send_o,
  output logic [7:0]                       cmd_type_o,
  output logic [7:0]                       req_id_o,
  output logic [7:0]                       channel_byte_o,
  output logic [3:0]                       payload_len_o,
  output logic [63:0]                      payload_word_o,
  output logic [2:0]                       status_o,
  output logic                             fail_o
);
  import ncsi_cbs_pkg::*;

  cfg_t cfg;
  req_t req_q, req_d;
  res_t res, res_q;
  logic in_vld_q, in_vld_d;
  logic out_vld_q, out_vld_d;
  logic advance;

  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  assign req_d = '{op: op_i, rsp_length: rsp_length_i, rsp_type: rsp_type_i,
                   rsp_id: rsp_id_i, rsp_code: rsp_code_i,
                   rsp_channel: rsp_channel_i, link_status: link_status_i};

  assign in_vld_d  = (in_valid_i && in_ready_o) || (in_vld_q && !advance);
  assign out_vld_d = advance || (out_vld_q && !out_ready_i);

  ncsi_cbs_cfg_regs u_cfg_regs (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .cfg_o (cfg)
  );

  ncsi_cbs_core u_core (
    .clk_i,
    .rst_ni,
    .fire_i (advance),
    .req_i  (req_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= req_d;
    end
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign send_o         = res_q.send;
  assign cmd_type_o     = res_q.cmd_type;
  assign req_id_o       = res_q.req_id;
  assign channel_byte_o = res_q.channel_byte;
  assign payload_len_o  = res_q.payload_len;
  assign payload_word_o = res_q.payload_word;
  assign status_o       = res_q.status;
  assign fail_o         = res_q.fail;

endmodule

>>> hw/rtl/ncsi_cbs_checker.sv
// port-level checker for the bring-up sequencer and its bind
module ncsi_cbs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        send_o,
  input logic [7:0]  cmd_type_o,
  input logic [7:0]  req_id_o,
  input logic [7:0]  channel_byte_o,
  input logic [3:0]  payload_len_o,
  input logic [63:0] payload_word_o,
  input logic [2:0]  status_o,
  input logic        fail_o
);
  import ncsi_cbs_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(req_id_o)
      && $stable(status_o) && $stable(send_o) && $stable(cmd_type_o))
    else $error("result changed while stalled");

  a_idle_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !send_o |-> cmd_type_o == '0 && req_id_o == '0
      && channel_byte_o == '0 && payload_len_o == '0 && payload_word_o == '0)
    else $error("request fields set without send");

  a_fail_timeout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fail_o |-> status_o == ST_TIMEOUT && !send_o)
    else $error("fail without timeout status");

  a_plen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && send_o |-> (payload_len_o == PlenNone
      || payload_len_o == PlenWord || payload_len_o == PlenDouble)
      && channel_byte_o[4:0] == ChanLowBits && status_o == ST_OK)
    else $error("bad request framing");

endmodule

bind ncsi_channel_bringup_sequencer_unit ncsi_cbs_checker u_checker (.*);
